// File: src/tls_client_hello_sni_locator_unit_macros.svh
// assertion macros for the tls server name locator
// used by the top level; needs clk and rst_n in scope
`ifndef TLS_CLIENT_HELLO_SNI_LOCATOR_UNIT_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_LOCATOR_UNIT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define TLSSNI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlssni assertion failed");

// consequent holds in the cycle after the antecedent
`define TLSSNI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlssni assertion failed");

`endif

// File: src/tlssni_pkg.sv
// types and constants for the tls server name locator
// no dependencies
`timescale 1ns / 1ps

package tlssni_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES_DEFAULT = 65535;

    localparam int unsigned TGT_W     = 18;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [7:0] FIRST_LEN_OFS_RESET = 8'h4c;
    localparam logic [7:0] RECORD_TYPE_RESET   = 8'h16;

    // register index taken from paddr[2]
    localparam logic REG_FIRST_LEN_OFS = 1'b0;
    localparam logic REG_RECORD_TYPE   = 1'b1;

    // offsets inside a server name extension, from its start
    localparam logic [TGT_W-1:0] NAME_LEN_HI  = 18'd7;
    localparam logic [TGT_W-1:0] NAME_LEN_LO  = 18'd8;
    localparam logic [TGT_W-1:0] NAME_DATA    = 18'd9;
    localparam logic [TGT_W-1:0] EXT_HDR_LEN  = 18'd4;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef enum logic [2:0] {
        PH_RECORD = 3'd0,
        PH_CIPHER = 3'd1,
        PH_COMP   = 3'd2,
        PH_BLOCK  = 3'd3,
        PH_EXT    = 3'd4,
        PH_NAME   = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

endpackage

// File: src/tls_client_hello_sni_locator_unit.sv
// tls clienthello server name locator, top level
// depends on tlssni_pkg and tls_client_hello_sni_locator_unit_macros.svh
//
//   channel | handshake          | beat
//   --------+--------------------+-------------------------------------
//   input   | in_valid/in_stall  | data_byte, last
//   output  | out_valid/out_stall| status, name_offset, name_length
//   config  | apb psel/penable   | paddr, pwdata, prdata
//
// one payload byte per cycle while in_stall is low; each byte is a compare and an 18-bit add on the
// parse target, done combinationally between the state registers
// the result is registered into the output register when it is free, else into the skid
// two result slots (output register and skid), in_stall rises only when both hold
// no clearing pass after reset, the first byte can come right away
`timescale 1ns / 1ps
`include "tls_client_hello_sni_locator_unit_macros.svh"

module tls_client_hello_sni_locator_unit #(
    parameter int unsigned MAX_PAYLOAD_BYTES = tlssni_pkg::MAX_PAYLOAD_BYTES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [15:0]                        name_offset,
    output logic [15:0]                        name_length,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlssni_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tlssni_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [tlssni_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import tlssni_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PAYLOAD_BYTES);

    // configuration
    logic [7:0] first_len_ofs_reg;
    logic [7:0] record_type_reg;
    logic       cfg_wr;

    // parse state
    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TGT_W-1:0]   tgt_reg, tgt_next;
    logic [7:0]         held_reg, held_next;
    logic [TGT_W-1:0]   ebe_reg, ebe_next;
    logic [1:0]         fs_reg, fs_next;
    logic [15:0]        fo_reg, fo_next;
    logic [15:0]        fl_reg, fl_next;

    // working copy after the start-of-payload clear
    phase_t             s_phase;
    logic [TGT_W-1:0]   s_tgt;
    logic [7:0]         s_held;
    logic [TGT_W-1:0]   s_ebe;
    logic [1:0]         s_fs;
    logic [15:0]        s_fo;
    logic [15:0]        s_fl;

    logic               in_acc;
    logic               in_range;
    logic [TGT_W-1:0]   pos_ext;
    logic [TGT_W-1:0]   rel_pos;
    logic               active;
    logic [15:0]        v16;
    logic [TGT_W-1:0]   t2;
    logic [TGT_W-1:0]   blk_end;
    logic [TGT_W-1:0]   ext_next;
    logic [POS_W-1:0]   pos_after;

    logic [1:0]         res_status;
    logic [15:0]        res_offset;
    logic [15:0]        res_length;

    // output register and skid
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [15:0]        out_offset_reg;
    logic [15:0]        out_length_reg;
    logic               skid_valid_reg;
    logic [1:0]         skid_status_reg;
    logic [15:0]        skid_offset_reg;
    logic [15:0]        skid_length_reg;
    logic               push;
    logic               pop;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_ofs_reg <= FIRST_LEN_OFS_RESET;
            record_type_reg   <= RECORD_TYPE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_FIRST_LEN_OFS: first_len_ofs_reg <= pwdata[7:0];
                REG_RECORD_TYPE:   record_type_reg   <= pwdata[7:0];
                default:           first_len_ofs_reg <= first_len_ofs_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FIRST_LEN_OFS: prdata = {24'd0, first_len_ofs_reg};
            REG_RECORD_TYPE:   prdata = {24'd0, record_type_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- parser ----------------
    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign in_range = pos_reg < POS_MAX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RECORD;
            pos_reg   <= '0;
            tgt_reg   <= TGT_W'(FIRST_LEN_OFS_RESET);
            held_reg  <= '0;
            ebe_reg   <= '0;
            fs_reg    <= ST_NONE;
            fo_reg    <= '0;
            fl_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
            held_reg  <= held_next;
            ebe_reg   <= ebe_next;
            fs_reg    <= fs_next;
            fo_reg    <= fo_next;
            fl_reg    <= fl_next;
        end
    end

    always_comb
    begin
        // byte 0 starts a fresh payload
        if (pos_reg == '0)
        begin
            s_phase = (data_byte == record_type_reg) ? PH_CIPHER : PH_DONE;
            s_tgt   = TGT_W'(first_len_ofs_reg);
            s_held  = '0;
            s_ebe   = '0;
            s_fs    = ST_NONE;
            s_fo    = '0;
            s_fl    = '0;
        end
        else
        begin
            s_phase = phase_reg;
            s_tgt   = tgt_reg;
            s_held  = held_reg;
            s_ebe   = ebe_reg;
            s_fs    = fs_reg;
            s_fo    = fo_reg;
            s_fl    = fl_reg;
        end

        pos_ext  = TGT_W'(pos_reg);
        rel_pos  = pos_ext - s_tgt;
        active   = (s_phase != PH_DONE) && (pos_ext >= s_tgt);
        v16      = {s_held, data_byte};
        t2       = s_tgt + TGT_W'(2);
        blk_end  = t2 + TGT_W'(v16);
        ext_next = s_tgt + EXT_HDR_LEN + TGT_W'(v16);

        phase_next = s_phase;
        tgt_next   = s_tgt;
        held_next  = s_held;
        ebe_next   = s_ebe;
        fs_next    = s_fs;
        fo_next    = s_fo;
        fl_next    = s_fl;

        if (active)
        begin
            case (s_phase)
                PH_CIPHER:
                begin
                    if (rel_pos == TGT_W'(0))
                    begin
                        held_next = data_byte;
                    end
                    else if (rel_pos == TGT_W'(1))
                    begin
                        tgt_next   = t2 + TGT_W'(v16);
                        phase_next = PH_COMP;
                    end
                end
                PH_COMP:
                begin
                    if (rel_pos == TGT_W'(0))
                    begin
                        tgt_next   = s_tgt + TGT_W'(1) + TGT_W'(data_byte);
                        phase_next = PH_BLOCK;
                    end
                end
                PH_BLOCK:
                begin
                    if (rel_pos == TGT_W'(0))
                    begin
                        held_next = data_byte;
                    end
                    else if (rel_pos == TGT_W'(1))
                    begin
                        tgt_next = t2;
                        // block length with the top bit set reads as negative
                        if (v16[15])
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            ebe_next   = blk_end;
                            phase_next = (t2 >= blk_end) ? PH_DONE : PH_EXT;
                        end
                    end
                end
                PH_EXT:
                begin
                    if (rel_pos == TGT_W'(0) || rel_pos == TGT_W'(2))
                    begin
                        held_next = data_byte;
                    end
                    else if (rel_pos == TGT_W'(1))
                    begin
                        if (v16 == 16'd0)
                        begin
                            fs_next    = ST_TRUNC;
                            phase_next = PH_NAME;
                        end
                    end
                    else if (rel_pos == TGT_W'(3))
                    begin
                        tgt_next = ext_next;
                        if (ext_next >= s_ebe)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (rel_pos == NAME_LEN_HI)
                    begin
                        held_next = data_byte;
                    end
                    else if (rel_pos == NAME_LEN_LO)
                    begin
                        fl_next    = v16;
                        fo_next    = 16'(s_tgt + NAME_DATA);
                        fs_next    = ST_FOUND;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        pos_after = in_range ? pos_reg + POS_W'(1) : pos_reg;

        // bytes past the size limit leave the parse untouched
        if (!in_range)
        begin
            phase_next = phase_reg;
            tgt_next   = tgt_reg;
            held_next  = held_reg;
            ebe_next   = ebe_reg;
            fs_next    = fs_reg;
            fo_next    = fo_reg;
            fl_next    = fl_reg;
        end

        // result of the payload ending on this beat
        if (fs_next == ST_FOUND && fo_next < 16'(pos_after))
        begin
            res_status = ST_FOUND;
            res_offset = fo_next;
            res_length = fl_next;
        end
        else if (fs_next != ST_NONE)
        begin
            res_status = ST_TRUNC;
            res_offset = '0;
            res_length = '0;
        end
        else
        begin
            res_status = ST_NONE;
            res_offset = '0;
            res_length = '0;
        end

        pos_next = pos_after;

        if (!in_acc)
        begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
            tgt_next   = tgt_reg;
            held_next  = held_reg;
            ebe_next   = ebe_reg;
            fs_next    = fs_reg;
            fo_next    = fo_reg;
            fl_next    = fl_reg;
        end
        else if (last)
        begin
            phase_next = PH_RECORD;
            pos_next   = '0;
            tgt_next   = TGT_W'(first_len_ofs_reg);
            held_next  = '0;
            ebe_next   = '0;
            fs_next    = ST_NONE;
            fo_next    = '0;
            fl_next    = '0;
        end
    end

    // ---------------- result queue ----------------
    assign push = in_acc && last;
    assign pop  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_status_reg  <= skid_status_reg;
                out_offset_reg  <= skid_offset_reg;
                out_length_reg  <= skid_length_reg;
                skid_status_reg <= res_status;
                skid_offset_reg <= res_offset;
                skid_length_reg <= res_length;
            end
            else
            begin
                out_status_reg <= res_status;
                out_offset_reg <= res_offset;
                out_length_reg <= res_length;
            end
        end
        else if (push)
        begin
            skid_status_reg <= res_status;
            skid_offset_reg <= res_offset;
            skid_length_reg <= res_length;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign name_offset = out_offset_reg;
    assign name_length = out_length_reg;

    // ---------------- assertions ----------------
    `TLSSNI_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `TLSSNI_ASSERT_NEXT(a_last_clears_parse, in_acc && last,
        pos_reg == '0 && phase_reg == PH_RECORD && fs_reg == ST_NONE)
    `TLSSNI_ASSERT_NEXT(a_held_result_spills, in_acc && last && out_valid_reg && out_stall,
        skid_valid_reg)
    `TLSSNI_ASSERT_SAME(a_no_name_zero_fields,
        out_valid_reg && out_status_reg != ST_FOUND,
        out_offset_reg == '0 && out_length_reg == '0)

endmodule

// File: tb/tb_tls_client_hello_sni_locator_unit.sv
// self-checking testbench for the tls clienthello server name locator
// depends on tlssni_pkg and tls_client_hello_sni_locator_unit; predicts one result per payload
`timescale 1ns / 1ps

module tb_tls_client_hello_sni_locator_unit;
    import tlssni_pkg::*;

    localparam int unsigned PAYLOAD_CAP = MAX_PAYLOAD_BYTES_DEFAULT;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned IDLE_PCT    = 36;
    localparam int unsigned PRINT_LIMIT = 50;
    localparam logic [CFG_ADDR_W-1:0] ADDR_FIRST_LEN_OFS = {REG_FIRST_LEN_OFS, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_RECORD_TYPE   = {REG_RECORD_TYPE, 2'b00};

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] name_offset;
        logic [15:0] name_length;
    } sni_result_t;

    typedef struct {
        bit          rec_ok;
        int unsigned cipher_len;
        int unsigned comp_len;
        int unsigned n_ext;
        bit          sni;
        int unsigned name_len;
        bit          blk_forced;
        logic [15:0] blk_val;
        int unsigned keep;
        int unsigned tail;
    } hello_spec_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            data_byte = 8'd0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            status;
    logic [15:0]           name_offset;
    logic [15:0]           name_length;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // configuration copy and parse state of the predictor
    logic [7:0]  cfg_first_len_ofs;
    logic [7:0]  cfg_record_type;
    logic [15:0] hs_pos;
    phase_t      hs_phase;
    logic [17:0] hs_target;
    logic [17:0] hs_block_end;
    logic [7:0]  hs_held;
    logic [1:0]  hs_found;
    logic [15:0] hs_name_ofs;
    logic [15:0] hs_name_len;

    sni_result_t expected_sni_q [$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_accepted = 0;
    int unsigned hold_cnt = 0;
    bit          snd_idle_en = 1'b1;
    bit          rcv_idle_en = 1'b1;

    tls_client_hello_sni_locator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .name_offset (name_offset),
        .name_length (name_length),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    function automatic void hs_restart();
        hs_pos       = 16'd0;
        hs_phase     = PH_RECORD;
        hs_target    = 18'(cfg_first_len_ofs);
        hs_held      = 8'd0;
        hs_block_end = '0;
        hs_found     = ST_NONE;
        hs_name_ofs  = '0;
        hs_name_len  = '0;
    endfunction

    function automatic void sni_predict_byte(logic [7:0] b, logic is_last);
        sni_result_t r;
        logic [15:0] p;
        logic [17:0] d;
        logic [15:0] v;
        if (hs_pos < 16'(PAYLOAD_CAP))
        begin
            p = hs_pos;
            if (p == 16'd0)
            begin
                hs_restart();
                hs_phase = (b == cfg_record_type) ? PH_CIPHER : PH_DONE;
            end
            if (hs_phase != PH_DONE && {2'b00, p} >= hs_target)
            begin
                d = {2'b00, p} - hs_target;
                v = {hs_held, b};
                case (hs_phase)
                    PH_CIPHER:
                        if (d == 18'd0)
                            hs_held = b;
                        else if (d == 18'd1)
                        begin
                            hs_target = hs_target + 18'd2 + 18'(v);
                            hs_phase  = PH_COMP;
                        end
                    PH_COMP:
                        if (d == 18'd0)
                        begin
                            hs_target = hs_target + 18'd1 + 18'(b);
                            hs_phase  = PH_BLOCK;
                        end
                    PH_BLOCK:
                        if (d == 18'd0)
                            hs_held = b;
                        else if (d == 18'd1)
                        begin
                            hs_target = hs_target + 18'd2;
                            // block length with the top bit set reads as negative
                            if (v[15])
                                hs_phase = PH_DONE;
                            else
                            begin
                                hs_block_end = hs_target + 18'(v);
                                hs_phase = (hs_target >= hs_block_end) ? PH_DONE : PH_EXT;
                            end
                        end
                    PH_EXT:
                        if (d == 18'd0 || d == 18'd2)
                            hs_held = b;
                        else if (d == 18'd1)
                        begin
                            if (hs_held == 8'd0 && b == 8'd0)
                            begin
                                hs_found = ST_TRUNC;
                                hs_phase = PH_NAME;
                            end
                        end
                        else if (d == 18'd3)
                        begin
                            hs_target = hs_target + EXT_HDR_LEN + 18'(v);
                            if (hs_target >= hs_block_end)
                                hs_phase = PH_DONE;
                        end
                    PH_NAME:
                        if (d == NAME_LEN_HI)
                            hs_held = b;
                        else if (d == NAME_LEN_LO)
                        begin
                            hs_name_len = v;
                            hs_name_ofs = 16'(hs_target + NAME_DATA);
                            hs_found    = ST_FOUND;
                            hs_phase    = PH_DONE;
                        end
                    default:
                        hs_phase = PH_DONE;
                endcase
            end
            hs_pos = p + 16'd1;
        end
        if (is_last)
        begin
            r = '0;
            // a captured name only counts when its first byte arrived
            if (hs_found == ST_FOUND && hs_name_ofs < hs_pos)
                r = {ST_FOUND, hs_name_ofs, hs_name_len};
            else if (hs_found != ST_NONE)
                r.status = ST_TRUNC;
            expected_sni_q.push_back(r);
            hs_restart();
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch in %s at %0t: got %0d, expected %0d", field, $time, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        sni_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sni_q.size() == 0)
                report_mismatch("unexpected result status", 16'(status), 16'd0);
            else
            begin
                want = expected_sni_q.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 16'(status), 16'(want.status));
                if (name_offset !== want.name_offset)
                    report_mismatch("name_offset", name_offset, want.name_offset);
                if (name_length !== want.name_length)
                    report_mismatch("name_length", name_length, want.name_length);
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            sni_predict_byte(data_byte, last);
            bytes_accepted++;
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else
            out_stall <= rcv_idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_tls_client_hello_sni_locator_unit failed");
        $finish;
    end

    function automatic void push16(ref byte_q_t q, input logic [15:0] v);
        q.push_back(v[15:8]);
        q.push_back(v[7:0]);
    endfunction

    function automatic hello_spec_t plain_spec();
        hello_spec_t s;
        s.rec_ok     = 1'b1;
        s.cipher_len = 4;
        s.comp_len   = 1;
        s.n_ext      = 1;
        s.sni        = 1'b1;
        s.name_len   = 5;
        s.blk_forced = 1'b0;
        s.blk_val    = 16'd0;
        s.keep       = 0;
        s.tail       = 1;
        return s;
    endfunction

    function automatic hello_spec_t random_spec();
        hello_spec_t s;
        s.rec_ok     = $urandom_range(0, 99) < 92;
        s.cipher_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400)
                                                    : $urandom_range(0, 40);
        s.comp_len   = $urandom_range(0, 3);
        s.n_ext      = $urandom_range(0, 3);
        s.sni        = $urandom_range(0, 99) < 80;
        s.name_len   = $urandom_range(0, 24);
        s.blk_forced = $urandom_range(0, 99) < 10;
        case ($urandom_range(0, 2))
            0:       s.blk_val = 16'h8000 | 16'($urandom);
            1:       s.blk_val = 16'd0;
            default: s.blk_val = 16'($urandom_range(1, 80));
        endcase
        s.keep = ($urandom_range(0, 99) < 25) ? $urandom_range(1, 3 * cfg_first_len_ofs + 80) : 0;
        s.tail = $urandom_range(0, 4);
        return s;
    endfunction

    function automatic void make_hello(input hello_spec_t s, output byte_q_t q);
        byte_q_t     ext;
        logic [15:0] clen;
        logic [15:0] elen;
        q = {};
        ext = {};
        if (!s.rec_ok)
        begin
            q.push_back(cfg_record_type + 8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 40 + cfg_first_len_ofs)) q.push_back(8'($urandom));
            return;
        end
        q.push_back(cfg_record_type);
        while (q.size() < cfg_first_len_ofs)
            q.push_back(8'($urandom));
        // at offset zero the record byte doubles as the high byte of the cipher length
        if (q.size() > cfg_first_len_ofs)
            clen = {q[0], s.cipher_len[7:0]};
        else
        begin
            clen = 16'(s.cipher_len);
            q.push_back(clen[15:8]);
        end
        q.push_back(clen[7:0]);
        repeat (clen) q.push_back(8'($urandom));
        q.push_back(8'(s.comp_len));
        repeat (s.comp_len) q.push_back(8'($urandom));
        repeat (s.n_ext)
        begin
            elen = 16'($urandom_range(0, 12));
            push16(ext, 16'($urandom_range(1, 65535)));
            push16(ext, elen);
            repeat (elen) ext.push_back(8'($urandom));
        end
        if (s.sni)
        begin
            push16(ext, 16'd0);
            push16(ext, 16'(s.name_len + 5));
            push16(ext, 16'(s.name_len + 3));
            ext.push_back(8'h00);
            push16(ext, 16'(s.name_len));
            repeat (s.name_len) ext.push_back(8'($urandom));
        end
        push16(q, s.blk_forced ? s.blk_val : 16'(ext.size()));
        foreach (ext[i])
            q.push_back(ext[i]);
        repeat (s.tail) q.push_back(8'($urandom));
        if (s.keep != 0 && s.keep < q.size())
            q = q[0:s.keep-1];
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (snd_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= is_last;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_payload(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_spec(input hello_spec_t s);
        byte_q_t q;
        make_hello(s, q);
        send_payload(q);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_sni_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (idx == REG_RECORD_TYPE) ? ADDR_RECORD_TYPE : ADDR_FIRST_LEN_OFS;
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RECORD_TYPE)
            cfg_record_type = value;
        else
            cfg_first_len_ofs = value;
    endtask

    task automatic set_config(input logic [7:0] ofs, input logic [7:0] rec);
        write_reg(REG_FIRST_LEN_OFS, ofs);
        write_reg(REG_RECORD_TYPE, rec);
    endtask

    task automatic test_reset_defaults();
        send_spec(plain_spec());
    endtask

    task automatic test_directed_cases();
        hello_spec_t s;
        byte_q_t     q;
        set_config(8'd4, RECORD_TYPE_RESET);
        s = plain_spec();
        send_spec(s);
        s.rec_ok = 1'b0;
        send_spec(s);
        q = '{cfg_record_type};
        send_payload(q);
        // cipher length cut after its high byte
        s = plain_spec();
        s.keep = 5;
        send_spec(s);
        s = plain_spec();
        s.blk_forced = 1'b1;
        s.blk_val = 16'h8000;
        send_spec(s);
        s.blk_val = 16'hffff;
        send_spec(s);
        s.blk_val = 16'd0;
        send_spec(s);
        // walk runs off the block without meeting a server name
        s = plain_spec();
        s.sni = 1'b0;
        s.n_ext = 2;
        send_spec(s);
        // type 0 seen but the name length never arrives
        s = plain_spec();
        s.n_ext = 0;
        s.keep = 20;
        send_spec(s);
        // name length complete, first name byte just missing
        s.keep = 23;
        send_spec(s);
        s = plain_spec();
        s.name_len = 0;
        send_spec(s);
        q = '{8'hff, 8'h00, 8'hff};
        send_payload(q);
    endtask

    task automatic test_backpressure();
        snd_idle_en = 1'b0;
        rcv_idle_en = 1'b0;
        hold_cnt <= 80;
        // one-byte payloads keep offering results while the receiver holds off
        repeat (30) send_byte(8'($urandom), 1'b1);
        send_spec(plain_spec());
        drain_results();
        snd_idle_en = 1'b1;
        rcv_idle_en = 1'b1;
    endtask

    task automatic test_random_hellos();
        logic [7:0]  ofs_sel;
        logic [7:0]  rec_sel;
        byte_q_t     q;
        int unsigned byte_mark;
        int unsigned payloads;
        for (int i = 0; i < 6; i++)
        begin
            case (i)
                0:       begin ofs_sel = FIRST_LEN_OFS_RESET; rec_sel = RECORD_TYPE_RESET; end
                1:       begin ofs_sel = 8'd0;   rec_sel = 8'd0;   end
                2:       begin ofs_sel = 8'd255; rec_sel = 8'd255; end
                3:       begin ofs_sel = 8'd1;   rec_sel = 8'd128; end
                4:       begin ofs_sel = 8'd9;   rec_sel = 8'($urandom); end
                default: begin ofs_sel = 8'($urandom_range(2, 40)); rec_sel = 8'($urandom); end
            endcase
            set_config(ofs_sel, rec_sel);
            // first setting runs without any idling on either side
            snd_idle_en = (i != 0);
            rcv_idle_en = (i != 0);
            byte_mark = bytes_accepted;
            payloads = 0;
            while (bytes_accepted - byte_mark < 100 && payloads < 12)
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    q = {};
                    repeat ($urandom_range(1, 60)) q.push_back(8'($urandom));
                end
                else
                    make_hello(random_spec(), q);
                send_payload(q);
                payloads++;
            end
        end
    endtask

    initial
    begin
        cfg_first_len_ofs = FIRST_LEN_OFS_RESET;
        cfg_record_type   = RECORD_TYPE_RESET;
        hs_restart();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_cases();
        test_backpressure();
        test_random_hellos();
        drain_results();
        if (mismatch_count == 0)
            $display("tb_tls_client_hello_sni_locator_unit passed");
        else
            $display("tb_tls_client_hello_sni_locator_unit failed");
        $finish;
    end

endmodule
